// File: hw/rtl/ecu_pkg.sv
// Shared constants for the easing curve unit: curve codes, fixed-point
// constants and the default table sizes. No dependencies.
package ecu_pkg;

    // Default table sizes.
    localparam int SINE_ENTRIES_DEF = 1024;
    localparam int EXP2_ENTRIES_DEF = 256;

    // Curve selector codes.
    localparam logic [2:0] OP_QUART_IN      = 3'd0;
    localparam logic [2:0] OP_QUART_OUT     = 3'd1;
    localparam logic [2:0] OP_QUART_INOUT   = 3'd2;
    localparam logic [2:0] OP_ELASTIC_IN    = 3'd3;
    localparam logic [2:0] OP_ELASTIC_OUT   = 3'd4;
    localparam logic [2:0] OP_ELASTIC_INOUT = 3'd5;

    // Table content selectors.
    localparam int ROM_SINE = 0;
    localparam int ROM_EXP2 = 1;

    // Fixed-point constants.
    localparam logic [16:0] ONE_Q16     = 17'd65536;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] LN2_Q30     = 64'd744261118;

endpackage

// File: hw/rtl/ecu_rom.sv
// Constant table with a registered read port: one turn of sine (signed Q16)
// or one octave of 2^(-j/DEPTH) (Q30). Depends on ecu_pkg.
module ecu_rom import ecu_pkg::*; #(
    parameter int TABLE_SEL = ROM_SINE,
    parameter int DEPTH     = SINE_ENTRIES_DEF,
    parameter int WIDTH     = 18
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic [$clog2(DEPTH)-1:0] addr,
    output logic [WIDTH-1:0]         data
);

    // Sine of 2*pi*k/DEPTH from a quarter-wave Taylor series.
    function automatic logic [17:0] sine_entry(input int unsigned k);
        logic [63:0] u;
        logic [63:0] f;
        logic [63:0] th;
        logic [63:0] th2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] m;
        logic [1:0]  quad;
        u = (64'(k) << 32) / 64'(DEPTH);
        quad = u[31:30];
        f = u & ((64'd1 << 30) - 64'd1);
        if (quad[0]) f = (64'd1 << 30) - f;
        th = (f * HALF_PI_Q30) >> 30;
        th2 = (th * th) >> 30;
        term = th;
        sum = th;
        for (int n = 1; n <= 6; n++) begin
            term = ((term * th2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) sum = sum - term;
            else sum = sum + term;
        end
        m = (sum + 64'd8192) >> 14;
        if (m > 64'd65536) m = 64'd65536;
        if (quad[1]) m = -m;
        return m[17:0];
    endfunction

    // 2^(-j/DEPTH) in Q30, as exp((1 - j/DEPTH) * ln2) / 2.
    function automatic logic [30:0] exp2_entry(input int unsigned j);
        logic [63:0] z;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] r;
        z = ((64'(DEPTH) - 64'(j)) * LN2_Q30) / 64'(DEPTH);
        term = 64'd1 << 30;
        sum = 64'd1 << 30;
        for (int n = 1; n <= 12; n++) begin
            term = ((term * z) >> 30) / 64'(n);
            sum = sum + term;
        end
        r = (sum + 64'd1) >> 1;
        return r[30:0];
    endfunction

    logic [WIDTH-1:0] rom_w [DEPTH];

    // Table contents, fixed at elaboration.
    for (genvar k = 0; k < DEPTH; k++) begin : g_entry
        if (TABLE_SEL == ROM_SINE) begin : g_sine
            assign rom_w[k] = WIDTH'(sine_entry(k));
        end else begin : g_exp2
            assign rom_w[k] = WIDTH'(exp2_entry(k));
        end
    end

    // Registered read.
    always_ff @(posedge aclk) begin
        if (en) begin
            data <= rom_w[addr];
        end
    end

endmodule

// File: hw/rtl/easing_curve_unit.sv
// Easing curve evaluator, top level: quartic and elastic curves in a
// nine-stage pipeline. Depends on ecu_pkg and ecu_rom.
//
//   Channel   Direction  tdata fields (low bit first)
//   s_axis    in         op[2:0], t[19:3], zero fill to 24 bits
//   m_axis    out        value[18:0] (two's complement), zero fill to 24 bits
//
// One item enters per cycle while s_tready is high. Each item passes through
// the nine register stages (index division, table reads and the amplitude
// multiplier) before m_tvalid rises for it. A stage loads whenever it is
// empty or the stage after it moves, so bubbles close up and a stall on
// m_axis loses nothing.
// Reset (aresetn low, synchronous) clears only the stage valid bits.
module easing_curve_unit import ecu_pkg::*; #(
    parameter int SINE_TABLE_ENTRIES = SINE_ENTRIES_DEF,
    parameter int EXP2_TABLE_ENTRIES = EXP2_ENTRIES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // op[2:0], t[19:3]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // value[18:0]
);

    localparam int NS = 9;
    localparam longint N = SINE_TABLE_ENTRIES;
    localparam longint M = EXP2_TABLE_ENTRIES;

    // Phase index arithmetic: pos = d*K + C, index = (pos / (den*2^18)) mod N.
    localparam longint C_A = 3 * 65536 * (31 * N + 2);
    localparam longint C_B = 9 * 65536 * (31 * N + 2);
    localparam longint K_A = 40 * N;
    localparam longint K_B = 80 * N;
    localparam int POS_W = $clog2(65536 * (359 * N + 18) + 1);
    localparam int P_W = POS_W - 18;
    localparam longint RD_A = (longint'(1) << P_W) / 3;
    localparam longint RD_B = (longint'(1) << P_W) / 9;
    localparam longint RN = (longint'(1) << P_W) / N;
    localparam int IDX_W = $clog2(SINE_TABLE_ENTRIES);
    localparam int J_W = $clog2(EXP2_TABLE_ENTRIES);
    localparam int JR_W = $clog2(EXP2_TABLE_ENTRIES + 1);
    localparam int JP_W = 17 + JR_W;

    localparam logic signed [POS_W:0] K_A_S = (POS_W + 1)'(K_A);
    localparam logic signed [POS_W:0] K_B_S = (POS_W + 1)'(K_B);
    localparam logic signed [POS_W:0] C_A_S = (POS_W + 1)'(C_A);
    localparam logic signed [POS_W:0] C_B_S = (POS_W + 1)'(C_B);

    // Result kinds and quartic finishing forms.
    localparam logic [1:0] KIND_CONST   = 2'd0;
    localparam logic [1:0] KIND_QUART   = 2'd1;
    localparam logic [1:0] KIND_ELASTIC = 2'd2;
    localparam logic [1:0] FIN_IN       = 2'd0;
    localparam logic [1:0] FIN_OUT      = 2'd1;
    localparam logic [1:0] FIN_HALF_LO  = 2'd2;
    localparam logic [1:0] FIN_HALF_HI  = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  fin;
        logic        big;       // in-out elastic: period 0.45, extra halving
        logic        neg_form;  // value = -(amp*sin) instead of 1 + amp*sin
        logic [16:0] const_v;
    } ctl_t;

    logic [NS-1:0] en;
    logic [NS-1:0] v_reg;
    ctl_t          ctl_reg [NS-1];
    ctl_t          ctl_next;

    logic [16:0]        x_reg, x_next;
    logic signed [17:0] d_reg, d_next;
    logic [16:0]        a_reg, a_next;

    logic [16:0]    x2_reg;
    logic [P_W-1:0] p_reg;
    logic [J_W-1:0] j_reg;
    logic [3:0]     ip_reg;

    logic [16:0]    q_reg;
    logic [P_W-1:0] qest_reg;
    logic [P_W-1:0] p2_reg;
    logic [3:0]     ip2_reg;
    logic [30:0]    ent_w;

    logic [P_W-1:0] qd_reg;
    logic [30:0]    amp_reg [3:6];
    logic [P_W-1:0] mm_reg;
    logic [P_W-1:0] qd4_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [17:0]    sine_w;
    logic [16:0]    r_reg;
    logic           sneg_reg;
    logic [18:0]    value_reg;

    // Stage enables: a stage loads when empty or when its successor moves.
    always_comb begin
        en[NS-1] = !v_reg[NS-1] || m_tready;
        for (int i = NS - 2; i >= 0; i--) begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = v_reg[NS-1];
    assign m_tdata  = {5'd0, value_reg};

    // Input decode: clamp t and set up both the quartic and elastic operands.
    always_comb begin
        logic [2:0]         op;
        logic [16:0]        t_in;
        logic [16:0]        tc;
        logic signed [18:0] d2;
        op = s_tdata[2:0];
        t_in = s_tdata[19:3];
        tc = (t_in > ONE_Q16) ? ONE_Q16 : t_in;
        d2 = $signed({1'b0, tc, 1'b0}) - 19'sd65536;
        ctl_next = '0;
        x_next = '0;
        d_next = '0;
        a_next = '0;
        case (op)
            OP_QUART_IN: begin
                ctl_next.kind = KIND_QUART;
                ctl_next.fin = FIN_IN;
                x_next = tc;
            end
            OP_QUART_OUT: begin
                ctl_next.kind = KIND_QUART;
                ctl_next.fin = FIN_OUT;
                x_next = ONE_Q16 - tc;
            end
            OP_QUART_INOUT: begin
                ctl_next.kind = KIND_QUART;
                if (tc < 17'd32768) begin
                    ctl_next.fin = FIN_HALF_LO;
                    x_next = {tc[15:0], 1'b0};
                end else begin
                    ctl_next.fin = FIN_HALF_HI;
                    x_next = 17'(18'd131072 - {tc, 1'b0});
                end
            end
            OP_ELASTIC_IN: begin
                ctl_next.kind = KIND_ELASTIC;
                ctl_next.neg_form = 1'b1;
                d_next = $signed({1'b0, tc}) - 18'sd65536;
                a_next = ONE_Q16 - tc;
            end
            OP_ELASTIC_OUT: begin
                ctl_next.kind = KIND_ELASTIC;
                d_next = $signed({1'b0, tc});
                a_next = tc;
            end
            OP_ELASTIC_INOUT: begin
                ctl_next.kind = KIND_ELASTIC;
                ctl_next.big = 1'b1;
                ctl_next.neg_form = d2[18];
                d_next = d2[17:0];
                a_next = d2[18] ? 17'(-d2) : d2[16:0];
            end
            default: begin
                ctl_next.kind = KIND_CONST;
            end
        endcase
        // Elastic curves pin the two ends exactly.
        if (ctl_next.kind == KIND_ELASTIC && tc == 17'd0) begin
            ctl_next.kind = KIND_CONST;
            ctl_next.const_v = '0;
        end else if (ctl_next.kind == KIND_ELASTIC && tc == ONE_Q16) begin
            ctl_next.kind = KIND_CONST;
            ctl_next.const_v = ONE_Q16;
        end
    end

    // Valid bits of the stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int i = 0; i < NS; i++) begin
                if (en[i]) begin
                    v_reg[i] <= (i == 0) ? s_tvalid : v_reg[(i == 0) ? 0 : i - 1];
                end
            end
        end
    end

    // Datapath stages.
    always_ff @(posedge aclk) begin
        logic signed [POS_W:0] pos;
        logic [19:0]           e;
        logic [JP_W-1:0]       jprod;
        logic [JP_W-17:0]      jraw;
        logic [32:0]           sq;
        logic [2*P_W-1:0]      qprod;
        logic [P_W+3:0]        dq;
        logic [P_W+3:0]        rr;
        logic [16:0]           qh;
        logic [31:0]           asum;
        logic [31:0]           rnd;
        logic [2*P_W-1:0]      mprod;
        logic [P_W-1:0]        rn;
        logic [16:0]           mag;
        logic [47:0]           prod;
        logic signed [19:0]    sr;
        logic signed [19:0]    val;
        ctl_t                  c3;

        // Stage 0: decoded operands.
        if (en[0]) begin
            ctl_reg[0] <= ctl_next;
            x_reg <= x_next;
            d_reg <= d_next;
            a_reg <= a_next;
        end

        // Stage 1: x^2, phase position, decay exponent split.
        if (en[1]) begin
            ctl_reg[1] <= ctl_reg[0];
            sq = 33'(x_reg) * 33'(x_reg) + 33'd32768;
            x2_reg <= sq[32:16];
            pos = (POS_W + 1)'(d_reg) * (ctl_reg[0].big ? K_B_S : K_A_S)
                + (ctl_reg[0].big ? C_B_S : C_A_S);
            p_reg <= pos[POS_W-1:18];
            e = 20'(a_reg) * 20'd10;
            jprod = JP_W'(e[15:0]) * JP_W'(M) + JP_W'(32768);
            jraw = jprod[JP_W-1:16];
            if (jraw >= (JP_W - 16)'(M)) begin
                j_reg <= '0;
                ip_reg <= e[19:16] + 4'd1;
            end else begin
                j_reg <= jraw[J_W-1:0];
                ip_reg <= e[19:16];
            end
        end

        // Stage 2: x^4, quotient estimate, exp2 table read (in ecu_rom).
        if (en[2]) begin
            ctl_reg[2] <= ctl_reg[1];
            sq = 33'(x2_reg) * 33'(x2_reg) + 33'd32768;
            q_reg <= sq[32:16];
            qprod = (2 * P_W)'(p_reg)
                  * (2 * P_W)'(ctl_reg[1].big ? RD_B : RD_A);
            qest_reg <= qprod[2*P_W-1:P_W];
            p2_reg <= p_reg;
            ip2_reg <= ip_reg;
        end

        // Stage 3: quartic finish, quotient correction, decay shift.
        if (en[3]) begin
            c3 = ctl_reg[2];
            qh = 17'((18'(q_reg) + 18'd1) >> 1);
            if (c3.kind == KIND_QUART) begin
                c3.kind = KIND_CONST;
                case (c3.fin)
                    FIN_IN:      c3.const_v = q_reg;
                    FIN_OUT:     c3.const_v = ONE_Q16 - q_reg;
                    FIN_HALF_LO: c3.const_v = qh;
                    FIN_HALF_HI: c3.const_v = ONE_Q16 - qh;
                    default:     c3.const_v = q_reg;
                endcase
            end
            ctl_reg[3] <= c3;
            dq = (P_W + 4)'(qest_reg) * (P_W + 4)'(ctl_reg[2].big ? 9 : 3);
            rr = (P_W + 4)'(p2_reg) - dq;
            if (rr >= (P_W + 4)'(ctl_reg[2].big ? 9 : 3)) begin
                qd_reg <= qest_reg + P_W'(1);
            end else begin
                qd_reg <= qest_reg;
            end
            rnd = (ip2_reg == 4'd0) ? 32'd0 : (32'd1 << (ip2_reg - 4'd1));
            asum = 32'(ent_w) + rnd;
            amp_reg[3] <= 31'(asum >> ip2_reg);
        end

        // Stage 4: estimate of the turn count for the modulo.
        if (en[4]) begin
            ctl_reg[4] <= ctl_reg[3];
            rn = P_W'(RN);
            mprod = (2 * P_W)'(qd_reg) * (2 * P_W)'(rn);
            mm_reg <= mprod[2*P_W-1:P_W];
            qd4_reg <= qd_reg;
            amp_reg[4] <= amp_reg[3];
        end

        // Stage 5: sine table index.
        if (en[5]) begin
            ctl_reg[5] <= ctl_reg[4];
            rr = (P_W + 4)'(qd4_reg) - (P_W + 4)'(mm_reg) * (P_W + 4)'(N);
            if (rr >= (P_W + 4)'(N)) begin
                rr = rr - (P_W + 4)'(N);
            end
            idx_reg <= rr[IDX_W-1:0];
            amp_reg[5] <= amp_reg[4];
        end

        // Stage 6: sine table read (in ecu_rom).
        if (en[6]) begin
            ctl_reg[6] <= ctl_reg[5];
            amp_reg[6] <= amp_reg[5];
        end

        // Stage 7: amplitude times sine magnitude, rounded.
        if (en[7]) begin
            ctl_reg[7] <= ctl_reg[6];
            mag = sine_w[17] ? 17'(-sine_w) : sine_w[16:0];
            prod = 48'(amp_reg[6]) * 48'(mag);
            if (ctl_reg[6].big) begin
                prod = prod + (48'd1 << 30);
                r_reg <= prod[47:31];
            end else begin
                prod = prod + (48'd1 << 29);
                r_reg <= prod[46:30];
            end
            sneg_reg <= sine_w[17];
        end

        // Stage 8: output register.
        if (en[8]) begin
            sr = sneg_reg ? -$signed({3'd0, r_reg}) : $signed({3'd0, r_reg});
            if (ctl_reg[7].kind == KIND_ELASTIC) begin
                val = ctl_reg[7].neg_form ? -sr : 20'sd65536 + sr;
            end else begin
                val = $signed({3'd0, ctl_reg[7].const_v});
            end
            value_reg <= val[18:0];
        end
    end

    // Decay mantissa table, read in stage 2.
    ecu_rom #(
        .TABLE_SEL (ROM_EXP2),
        .DEPTH     (EXP2_TABLE_ENTRIES),
        .WIDTH     (31)
    ) u_exp2_rom (
        .aclk (aclk),
        .en   (en[2]),
        .addr (j_reg),
        .data (ent_w)
    );

    // Sine table, read in stage 6.
    ecu_rom #(
        .TABLE_SEL (ROM_SINE),
        .DEPTH     (SINE_TABLE_ENTRIES),
        .WIDTH     (18)
    ) u_sine_rom (
        .aclk (aclk),
        .en   (en[6]),
        .addr (idx_reg),
        .data (sine_w)
    );

endmodule

// File: tb/sv/easing_curve_unit_test.sv
// Self-checking testbench for easing_curve_unit: directed and random curve
// requests, checked against a bit-exact predictor kept here.
// Depends on ecu_pkg and the easing_curve_unit RTL.
`timescale 1ns / 100ps

// Holds the eased values still due and compares each result with the oldest.
class ease_scoreboard;
    logic [18:0] due_values[$];
    int          fault_count;

    function new();
        fault_count = 0;
    endfunction

    // Table value for sine at turn fraction k/N, signed Q16.
    static function longint sine_rom(longint unsigned k);
        longint unsigned u, f, th, th2, term, sum, m;
        int unsigned quad;
        u = (k << 32) / ecu_pkg::SINE_ENTRIES_DEF;
        quad = 32'((u >> 30) & 3);
        f = u & ((64'd1 << 30) - 1);
        if (quad & 1) f = (64'd1 << 30) - f;
        th = (f * ecu_pkg::HALF_PI_Q30) >> 30;
        th2 = (th * th) >> 30;
        term = th;
        sum = th;
        for (int n = 1; n <= 6; n++) begin
            term = ((term * th2) >> 30) / ((2 * n) * (2 * n + 1));
            if (n & 1) sum -= term; else sum += term;
        end
        m = (sum + 8192) >> 14;
        if (m > 65536) m = 65536;
        return (quad >= 2) ? -longint'(m) : longint'(m);
    endfunction

    // Sine of the elastic phase 2*pi*(d*num/den - 1/4).
    static function longint phase_sine(longint d, longint num, longint den);
        longint n, dd, numer;
        longint unsigned pos;
        n = ecu_pkg::SINE_ENTRIES_DEF;
        dd = 4 * den * 65536;
        numer = d * num * 4 * n - den * 65536 * n;
        pos = longint'(numer + dd * n * 8 + dd / 2);
        return sine_rom((pos / longint'(dd)) % n);
    endfunction

    // 2^(-j/M) in Q30 from a truncated exponential series.
    static function longint unsigned pow2_rom(longint unsigned j);
        longint unsigned m, z, term, sum;
        m = ecu_pkg::EXP2_ENTRIES_DEF;
        z = ((m - j) * ecu_pkg::LN2_Q30) / m;
        term = 64'd1 << 30;
        sum = term;
        for (int n = 1; n <= 12; n++) begin
            term = ((term * z) >> 30) / n;
            sum += term;
        end
        return (sum + 1) >> 1;
    endfunction

    // Envelope 2^(-10a), a in Q16, result in Q30.
    static function longint unsigned decay(longint unsigned a);
        longint unsigned e, fr, j, ent;
        int unsigned ip;
        e = 10 * a;
        ip = 32'(e >> 16);
        fr = e & 16'hFFFF;
        j = (fr * ecu_pkg::EXP2_ENTRIES_DEF + 32768) >> 16;
        if (j >= ecu_pkg::EXP2_ENTRIES_DEF) begin
            j = 0;
            ip++;
        end
        ent = pow2_rom(j);
        if (ip == 0) return ent;
        return (ent + (64'd1 << (ip - 1))) >> ip;
    endfunction

    static function longint amp_times_sine(longint unsigned amp, longint s, int sh);
        longint unsigned mag, r;
        mag = (s < 0) ? longint'(-s) : longint'(s);
        r = (amp * mag + (64'd1 << (sh - 1))) >> sh;
        return (s < 0) ? -longint'(r) : longint'(r);
    endfunction

    static function longint unsigned fourth_power(longint unsigned x);
        longint unsigned x2;
        x2 = (x * x + 32768) >> 16;
        return (x2 * x2 + 32768) >> 16;
    endfunction

    // Eased value for one request, Q16.
    static function logic [18:0] eased_value(logic [2:0] op, logic [16:0] t_in);
        longint unsigned t;
        longint v, d;
        t = (t_in > 65536) ? 65536 : t_in;
        v = 0;
        case (op)
            ecu_pkg::OP_QUART_IN: v = fourth_power(t);
            ecu_pkg::OP_QUART_OUT: v = 65536 - longint'(fourth_power(65536 - t));
            ecu_pkg::OP_QUART_INOUT: begin
                if (t < 32768) v = (fourth_power(2 * t) + 1) >> 1;
                else v = 65536 - longint'((fourth_power(131072 - 2 * t) + 1) >> 1);
            end
            ecu_pkg::OP_ELASTIC_IN, ecu_pkg::OP_ELASTIC_OUT,
            ecu_pkg::OP_ELASTIC_INOUT: begin
                // Elastic curves pin both ends exactly.
                if (t == 0) v = 0;
                else if (t >= 65536) v = 65536;
                else if (op == ecu_pkg::OP_ELASTIC_IN) begin
                    d = longint'(t) - 65536;
                    v = -amp_times_sine(decay(65536 - t), phase_sine(d, 10, 3), 30);
                end else if (op == ecu_pkg::OP_ELASTIC_OUT) begin
                    v = 65536 + amp_times_sine(decay(t), phase_sine(t, 10, 3), 30);
                end else begin
                    d = 2 * longint'(t) - 65536;
                    if (d < 0)
                        v = -amp_times_sine(decay(-d), phase_sine(d, 20, 9), 31);
                    else
                        v = 65536 + amp_times_sine(decay(d), phase_sine(d, 20, 9), 31);
                end
            end
            default: v = 0;
        endcase
        return v[18:0];
    endfunction

    function void note_request(logic [2:0] op, logic [16:0] t);
        due_values.push_back(eased_value(op, t));
    endfunction

    function void check_value(logic [18:0] actual);
        logic [18:0] want;
        if (due_values.size() == 0) begin
            $error("value: unexpected result %0d", $signed(actual));
            fault_count++;
            return;
        end
        want = due_values.pop_front();
        if (want !== actual) begin
            $error("value: expected %0d, actual %0d", $signed(want), $signed(actual));
            fault_count++;
        end
    endfunction
endclass

module easing_curve_unit_test;
    import ecu_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    ease_scoreboard board = new();
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    longint      cycle_count = 0;

    easing_curve_unit dut (.*);

    always #5 aclk = ~aclk;

    // Cycle limit: far above the slowest correct run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 200000) begin
            $display("easing_curve_unit_test: errors");
            $finish;
        end
    end

    // Receiver: random stalls, every result transfer is checked.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_value(m_tdata[18:0]);
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // One request transfer, with random idle cycles ahead of it.
    task automatic send_request(logic [2:0] op, logic [16:0] t);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'd0, t, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_request(op, t);
    endtask

    // Random request: mostly legal t, some above 1.0, some unused selectors.
    task automatic send_random();
        logic [2:0]  op;
        logic [16:0] t;
        op = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(5));
        case ($urandom_range(9))
            0: t = 17'($urandom);
            1: t = 17'($urandom_range(3));
            2: t = 17'(65536 - $urandom_range(3));
            default: t = 17'($urandom_range(65536));
        endcase
        send_request(op, t);
    endtask

    initial begin
        logic [16:0] edge_t[7];
        edge_t = '{17'd0, 17'd1, 17'd32767, 17'd32768, 17'd65535, 17'd65536, 17'h1FFFF};
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: every curve at the ends, the midpoint and past 1.0.
        send_idle_pct = 22;
        recv_idle_pct = 55;
        for (int op = 0; op < 8; op++)
            for (int i = 0; i < 7; i++) send_request(3'(op), edge_t[i]);

        // Random in three idling phases.
        repeat (600) send_random();
        send_idle_pct = 55;
        recv_idle_pct = 22;
        repeat (600) send_random();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (600) send_random();
        s_tvalid <= 1'b0;

        while (board.due_values.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (board.fault_count == 0 && board.due_values.size() == 0)
            $display("easing_curve_unit_test: clean");
        else
            $display("easing_curve_unit_test: errors");
        $finish;
    end
endmodule
